@@ design/assert_macros.svh @@
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

`endif

@@ design/skm_pkg.sv @@
// Package: item types and constants of the sorted key set membership block.
package skm_pkg;

    localparam int KEY_W          = 32;
    localparam int TABLE_DEPTH_DEF = 1024;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] key;
        logic                    group_last;
    } t_in;

    typedef struct packed {
        logic any_found;
        logic overflowed;
    } t_out;

endpackage

@@ design/skm_ram.sv @@
// Key table memory: one write port, one read port with registered read data.
module skm_ram #(
    parameter int DEPTH = skm_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [skm_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [skm_pkg::KEY_W-1:0] o_rdata
);

    logic [skm_pkg::KEY_W-1:0] mem [DEPTH];
    logic [skm_pkg::KEY_W-1:0] r_rdata;

    // write-first: reading the slot being written returns the new key
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= (i_we && i_waddr == i_raddr) ? i_wdata : mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/sorted_key_set_membership.sv @@
// Top level: key table with load, in-place insertion sort and binary-search queries.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+------------------------------------
//  item in  | i_start, o_busy, i_item        | taken when i_start && !o_busy
//  result   | o_done, o_result               | one-cycle strobe, cannot be stalled
//
// Operation: a load item is written straight into the table in its accept cycle;
// busy never rises. A query runs a binary search over the sorted keys, reading
// the lowest key, the highest key and then midpoints, all through the
// single read port of the key memory. The first query after a load that stored
// a key, with more than one key held, first runs an insertion sort through that
// same port, shifting each larger key up one slot before placing the element.
// An empty table answers without a memory read, in the cycle after the query.
// Reset clears state, count and flags (sorted set); the table needs no clearing pass.
// Results are strobed for one cycle; the receiver has no way to stall them.
`include "assert_macros.svh"

module sorted_key_set_membership #(
    parameter int TABLE_DEPTH = skm_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  skm_pkg::t_in  i_item,
    output logic          o_busy,
    output logic          o_done,
    output skm_pkg::t_out o_result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = skm_pkg::KEY_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;  // sort: element i arrives
    localparam logic [2:0] S_CMP   = 3'd2;  // sort: compare T[j-1] with item
    localparam logic [2:0] S_PLACE = 3'd3;  // sort: drop item at slot 0
    localparam logic [2:0] S_FIRST = 3'd4;  // search: lowest key arrives
    localparam logic [2:0] S_LAST  = 3'd5;  // search: highest key arrives
    localparam logic [2:0] S_PROBE = 3'd6;  // search: midpoint arrives

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_sorted, n_sorted;
    logic                 r_ghit, n_ghit;
    logic                 r_ovf, n_ovf;
    logic                 r_done, n_done;
    logic                 r_found, n_found;
    logic [AW-1:0]        r_i, n_i;
    logic [AW-1:0]        r_j, n_j;
    logic [AW-1:0]        r_lo, n_lo;
    logic [AW-1:0]        r_hi, n_hi;
    logic signed [KW-1:0] r_item, n_item;
    logic signed [KW-1:0] r_key, n_key;
    logic                 r_last, n_last;

    // memory port
    logic          we;
    logic [AW-1:0] waddr;
    logic [KW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [KW-1:0] rdata;
    logic signed [KW-1:0] rkey;

    logic          accept;
    logic          finish;
    logic          hit;
    logic          last_flag;
    logic [AW-1:0] mid;
    logic [AW-1:0] top_idx;

    skm_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rkey    = $signed(rdata);
    assign accept  = i_start && !o_busy;
    assign top_idx = AW'(r_count - CW'(1));

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_sorted  = r_sorted;
        n_ghit    = r_ghit;
        n_ovf     = r_ovf;
        n_done    = 1'b0;
        n_found   = r_found;
        n_i       = r_i;
        n_j       = r_j;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_item    = r_item;
        n_key     = r_key;
        n_last    = r_last;
        we        = 1'b0;
        waddr     = r_j;
        wdata     = r_item;
        raddr     = '0;
        finish    = 1'b0;
        hit       = 1'b0;
        last_flag = r_last;
        mid       = '0;

        unique case (r_state)
            S_IDLE: begin
                last_flag = i_item.group_last;
                if (accept) begin
                    if (i_item.operation == skm_pkg::OP_LOAD) begin
                        if (r_count < CW'(TABLE_DEPTH)) begin
                            we       = 1'b1;
                            waddr    = AW'(r_count);
                            wdata    = i_item.key;
                            n_count  = r_count + CW'(1);
                            n_sorted = 1'b0;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        n_key  = i_item.key;
                        n_last = i_item.group_last;
                        if (r_count == '0) begin
                            // empty table: nothing can match
                            finish = 1'b1;
                        end else if (!r_sorted && r_count > CW'(1)) begin
                            raddr   = AW'(1);
                            n_i     = AW'(1);
                            n_state = S_FETCH;
                        end else begin
                            n_sorted = 1'b1;
                            raddr    = '0;
                            n_state  = S_FIRST;
                        end
                    end
                end
            end
            S_FETCH: begin
                n_item  = rkey;
                n_j     = r_i;
                raddr   = r_i - AW'(1);
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rkey > r_item) begin
                    // shift the larger key up one slot
                    we    = 1'b1;
                    waddr = r_j;
                    wdata = rdata;
                    n_j   = r_j - AW'(1);
                    if (r_j != AW'(1)) begin
                        raddr = r_j - AW'(2);
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    we    = 1'b1;
                    waddr = r_j;
                    wdata = r_item;
                    n_i   = r_i + AW'(1);
                    if (CW'(r_i) + CW'(1) < r_count) begin
                        raddr   = r_i + AW'(1);
                        n_state = S_FETCH;
                    end else begin
                        n_sorted = 1'b1;
                        raddr    = '0;
                        n_state  = S_FIRST;
                    end
                end
            end
            S_PLACE: begin
                we    = 1'b1;
                waddr = r_j;
                wdata = r_item;
                n_i   = r_i + AW'(1);
                if (CW'(r_i) + CW'(1) < r_count) begin
                    raddr   = r_i + AW'(1);
                    n_state = S_FETCH;
                end else begin
                    n_sorted = 1'b1;
                    raddr    = '0;
                    n_state  = S_FIRST;
                end
            end
            S_FIRST: begin
                if (r_key < rkey) begin
                    finish = 1'b1;
                end else if (r_key == rkey) begin
                    hit    = 1'b1;
                    finish = 1'b1;
                end else begin
                    raddr   = top_idx;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_lo = '0;
                n_hi = top_idx;
                mid  = AW'(({1'b0, n_lo} + {1'b0, n_hi}) >> 1);
                if (r_key > rkey) begin
                    finish = 1'b1;
                end else if (r_key == rkey) begin
                    hit    = 1'b1;
                    finish = 1'b1;
                end else if ({1'b0, n_lo} + (AW+1)'(1) < {1'b0, n_hi}) begin
                    raddr   = mid;
                    n_state = S_PROBE;
                end else begin
                    finish = 1'b1;
                end
            end
            S_PROBE: begin
                // raddr of the last cycle is still the midpoint: r_lo/r_hi unchanged
                if (rkey == r_key) begin
                    hit    = 1'b1;
                    finish = 1'b1;
                end else begin
                    if (rkey < r_key) begin
                        n_lo = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
                    end else begin
                        n_hi = AW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
                    end
                    mid = AW'(({1'b0, n_lo} + {1'b0, n_hi}) >> 1);
                    if ({1'b0, n_lo} + (AW+1)'(1) < {1'b0, n_hi}) begin
                        raddr = mid;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_state = S_IDLE;
            if (last_flag) begin
                n_done  = 1'b1;
                n_found = r_ghit || hit;
                n_ghit  = 1'b0;
            end else begin
                n_ghit = r_ghit || hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_sorted <= 1'b1;
            r_ghit   <= 1'b0;
            r_ovf    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_sorted <= n_sorted;
            r_ghit   <= n_ghit;
            r_ovf    <= n_ovf;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found <= n_found;
        r_i     <= n_i;
        r_j     <= n_j;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_item  <= n_item;
        r_key   <= n_key;
        r_last  <= n_last;
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_done              = r_done;
    assign o_result.any_found  = r_found;
    assign o_result.overflowed = r_ovf;

    // checks
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH))
    `ASSERT_NEXT(a_load_no_busy, i_clk, i_rst_n, accept && i_item.operation == skm_pkg::OP_LOAD, !o_busy)
    `ASSERT_SAME(a_done_after_query, i_clk, i_rst_n, o_done, $past(o_busy) || $past(accept))
    `ASSERT_SAME(a_search_sorted, i_clk, i_rst_n, r_state == S_FIRST || r_state == S_PROBE, r_sorted)
    `ASSERT_NEXT(a_done_clears_group, i_clk, i_rst_n, n_done, !r_ghit)

endmodule
